// ----- src/chained_hash_set_insert_defines.svh -----
// assertion macros shared by the checker of the chained hash set insert block
// depends on nothing; included by name where assertions are written
`ifndef CHAINED_HASH_SET_INSERT_DEFINES_SVH
`define CHAINED_HASH_SET_INSERT_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define CHS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CHS_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/chs_pkg.sv -----
// types and fixed constants of the chained hash set insert block
// no dependencies; imported by the controller and the remainder unit
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

   // width of the divisor register
   localparam int DIV_W = 5;

   // result codes
   typedef enum logic [1:0] {
      INS_OK   = 2'd0,
      INS_DUP  = 2'd1,
      INS_FULL = 2'd2
   } chs_status_type;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_FILL_RD,
      ST_LOAD_FILL,
      ST_SCAN,
      ST_DECIDE,
      ST_DONE
   } chs_state_type;

   // status returned by the remainder unit
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] rem;
   } chs_mod_rsp_type;

endpackage

`default_nettype wire

// ----- src/chs_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module chs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/chs_mod_unit.sv -----
// iterative remainder unit: key modulo a small divisor, four key bits per cycle
// depends on chs_pkg
`timescale 1ns / 1ps
`default_nettype none

module chs_mod_unit
   import chs_pkg::*;
#(
   parameter int KEY_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [KEY_WIDTH-1:0] key,
   input  wire logic [DIV_W-1:0]     divisor,
   output chs_mod_rsp_type           mod_rsp
);

   localparam int RADIX   = 4;
   localparam int KEY_PAD = ((KEY_WIDTH + RADIX - 1) / RADIX) * RADIX;
   localparam int STEPS   = KEY_PAD / RADIX;
   localparam int CNT_W   = $clog2(STEPS + 1);

   logic [KEY_PAD-1:0] sh_ff;
   logic [DIV_W-1:0]   rem_ff;
   logic [DIV_W-1:0]   d_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIV_W-1:0]   rem_next;

   // one restoring step: bring in a bit, subtract once if it fits
   function automatic logic [DIV_W-1:0] mod_step(input logic [DIV_W-1:0] r,
                                                 input logic b,
                                                 input logic [DIV_W-1:0] d);
      logic [DIV_W:0] t;
      begin
         t = {r, b};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
         end
         return t[DIV_W-1:0];
      end
   endfunction

   // four dependent steps on the top key bits
   always_comb begin
      rem_next = rem_ff;
      for (int i = 0; i < RADIX; i++) begin
         rem_next = mod_step(rem_next, sh_ff[KEY_PAD-1-i], d_ff);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= KEY_PAD'(key);
         rem_ff <= '0;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         sh_ff  <= sh_ff << RADIX;
         rem_ff <= rem_next;
      end
   end

   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

// ----- src/chained_hash_set_insert.sv -----
// Hash set insert block. Each request item carries one key; the key goes to
// bucket key mod divisor, the bucket is searched, and the key is appended
// unless it is already there or the bucket is full. Each item gives one
// response item with a status (inserted, duplicate, full) and the bucket.
// Channels: req_* in and rsp_* out, both valid/stall; an item moves on a
// clock edge with valid high and stall low. csr_write_en loads the divisor
// (0 acts as 1, values above NUM_BUCKETS act as NUM_BUCKETS); write it only
// while no item is in flight.
// Processing: one item at a time. After acceptance, the remainder unit
// computes the bucket, the fill count of that bucket is read, the bucket
// scan compares the stored keys one by one and stops at a duplicate, and
// then the decision and the response load follow; a duplicate skips the
// decision. The scan rate is set by the single read port of the key memory.
// Reset: synchronous; afterwards the fill count memory is swept to zero
// with req_stall high during the sweep.
// Output: the response sits in a register; while rsp_stall is high it holds,
// and a finished item waits in the controller until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_set_insert
   import chs_pkg::*;
#(
   parameter int NUM_BUCKETS  = 16,
   parameter int BUCKET_DEPTH = 8,
   parameter int KEY_WIDTH    = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [KEY_WIDTH-1:0]           req_key_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [1:0]                     rsp_insert_status,
   output logic      [$clog2(NUM_BUCKETS)-1:0] rsp_bucket_index,
   input  wire logic                           csr_write_en,
   input  wire logic [DIV_W-1:0]               csr_hash_divisor
);

   localparam int BKT_W   = $clog2(NUM_BUCKETS);
   localparam int ENT_N   = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int ENT_AW  = $clog2(ENT_N);
   localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
   localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(13);

   chs_state_type        state_ff, state_in;
   logic [DIV_W-1:0]     divisor_ff;
   logic [DIV_W-1:0]     div_eff;
   logic [BKT_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [BKT_W-1:0]     bucket_ff, bucket_in;
   logic [ENT_AW-1:0]    base_ff, base_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [FILL_W-1:0]    iss_ff, iss_in;
   chs_status_type       status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [BKT_W-1:0]     rsp_bucket_ff, rsp_bucket_in;

   logic                 mod_start;
   chs_mod_rsp_type      mod_rsp;

   logic                 fill_we;
   logic [BKT_W-1:0]     fill_waddr;
   logic [FILL_W-1:0]    fill_wdata;
   logic                 fill_re;
   logic [FILL_W-1:0]    fill_rdata;
   logic                 ent_we;
   logic [ENT_AW-1:0]    ent_waddr;
   logic                 ent_re;
   logic [ENT_AW-1:0]    ent_raddr;
   logic [KEY_WIDTH-1:0] ent_rdata;

   // effective divisor, kept within 1 .. NUM_BUCKETS
   always_comb begin
      div_eff = divisor_ff;
      if (divisor_ff == '0) begin
         div_eff = DIV_W'(1);
      end else if (32'(divisor_ff) > NUM_BUCKETS) begin
         div_eff = DIV_W'(NUM_BUCKETS);
      end
   end

   // remainder unit
   chs_mod_unit #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .key     (req_key_value),
      .divisor (div_eff),
      .mod_rsp (mod_rsp)
   );

   // per-bucket fill counts
   chs_ram #(
      .WIDTH (FILL_W),
      .DEPTH (NUM_BUCKETS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_en   (fill_re),
      .rd_addr (bucket_ff),
      .rd_data (fill_rdata)
   );

   // stored keys, bucket after bucket
   chs_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (ENT_N)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (key_ff),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      key_in        = key_ff;
      bucket_in     = bucket_ff;
      base_in       = base_ff;
      fill_in       = fill_ff;
      iss_in        = iss_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      mod_start     = 1'b0;
      fill_we       = 1'b0;
      fill_waddr    = bucket_ff;
      fill_wdata    = fill_ff + 1'b1;
      fill_re       = 1'b0;
      ent_we        = 1'b0;
      ent_waddr     = base_ff + ENT_AW'(fill_ff);
      ent_re        = 1'b0;
      ent_raddr     = base_ff + ENT_AW'(iss_ff);

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // sweep fill counts to zero
         ST_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_cnt_ff;
            fill_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == BKT_W'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // take a key and start the remainder
         ST_IDLE: begin
            if (req_valid) begin
               key_in    = req_key_value;
               mod_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (mod_rsp.done) begin
               bucket_in = BKT_W'(mod_rsp.rem);
               state_in  = ST_FILL_RD;
            end
         end
         // read the bucket fill count, form the bucket base address
         ST_FILL_RD: begin
            fill_re  = 1'b1;
            base_in  = ENT_AW'(32'(bucket_ff) * BUCKET_DEPTH);
            state_in = ST_LOAD_FILL;
         end
         // capture fill, issue the first key read unless the bucket is empty
         ST_LOAD_FILL: begin
            fill_in = fill_rdata;
            if (fill_rdata == '0) begin
               state_in = ST_DECIDE;
            end else begin
               ent_re    = 1'b1;
               ent_raddr = base_ff;
               iss_in    = FILL_W'(1);
               state_in  = ST_SCAN;
            end
         end
         // compare one stored key per cycle, next read in flight
         ST_SCAN: begin
            if (ent_rdata == key_ff) begin
               status_in = INS_DUP;
               state_in  = ST_DONE;
            end else if (iss_ff == fill_ff) begin
               state_in = ST_DECIDE;
            end else begin
               ent_re   = 1'b1;
               iss_in   = iss_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         // append the key or report a full bucket
         ST_DECIDE: begin
            if (fill_ff == FILL_W'(BUCKET_DEPTH)) begin
               status_in = INS_FULL;
            end else begin
               ent_we    = 1'b1;
               fill_we   = 1'b1;
               status_in = INS_OK;
            end
            state_in = ST_DONE;
         end
         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_bucket_in = bucket_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         divisor_ff   <= DIV_RESET;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            divisor_ff <= csr_hash_divisor;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      bucket_ff     <= bucket_in;
      base_ff       <= base_in;
      fill_ff       <= fill_in;
      iss_ff        <= iss_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_insert_status = rsp_status_ff;
   assign rsp_bucket_index  = rsp_bucket_ff;

endmodule

`default_nettype wire

// ----- src/chs_checker.sv -----
// port-level checks of the chained hash set insert block, bound to the top level
// depends on chained_hash_set_insert_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "chained_hash_set_insert_defines.svh"

module chs_checker #(
   parameter int NUM_BUCKETS = 16
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [1:0]                     rsp_insert_status,
   input wire logic [$clog2(NUM_BUCKETS)-1:0] rsp_bucket_index
);

   // fill count sweep keeps requests out right after reset
   `CHS_ASSERT(a_stall_after_reset, clock,
      reset |=> req_stall,
      "request taken during clear")

   // one item at a time: stall rises right after an accept
   `CHS_ASSERT_RST(a_busy_after_accept, clock, reset,
      (req_valid && !req_stall) |=> req_stall,
      "second item taken while busy")

   // a result cannot appear the cycle after its item is taken
   `CHS_ASSERT_RST(a_no_instant_result, clock, reset,
      (req_valid && !req_stall) |=> !$rose(rsp_valid),
      "result too early")

   // only defined status codes, bucket inside the table
   `CHS_ASSERT_RST(a_status_code, clock, reset,
      rsp_valid |-> (rsp_insert_status != 2'd3) &&
         (32'(rsp_bucket_index) < NUM_BUCKETS),
      "bad result fields")

   // stalled result holds
   `CHS_ASSERT_RST(a_rsp_hold, clock, reset,
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_insert_status) &&
         $stable(rsp_bucket_index),
      "stalled result changed")

endmodule

bind chained_hash_set_insert chs_checker #(.NUM_BUCKETS(NUM_BUCKETS)) u_chs_checker (.*);

`default_nettype wire

// ----- tb/chained_hash_set_insert_tb.sv -----
// testbench for the chained hash set insert block: a bucket and status predictor
// in a small scoreboard class, directed and random key traffic, divisor changes
// depends on chs_pkg and the chained_hash_set_insert module
`timescale 1ns / 1ps

// predicts the status and bucket of every accepted key and checks the responses
class hash_set_scoreboard;
   localparam int BUCKETS = 16;
   localparam int DEPTH   = 8;

   typedef struct {
      logic [15:0]                key;
      chs_pkg::chs_status_type    status;
      logic [3:0]                 bucket;
   } insert_outcome_type;

   logic [4:0]         divisor_reg;
   logic [15:0]        stored_keys [BUCKETS][DEPTH];
   int unsigned        bucket_count [BUCKETS];
   insert_outcome_type outcome_q [$];
   int unsigned        errors;
   int unsigned        checked;
   int unsigned        n_inserted;
   int unsigned        n_duplicate;
   int unsigned        n_full;

   function new();
      divisor_reg = 5'd13;
      foreach (bucket_count[i]) bucket_count[i] = 0;
      errors = 0;
      checked = 0;
      n_inserted = 0;
      n_duplicate = 0;
      n_full = 0;
   endfunction

   function void set_divisor(input logic [4:0] d);
      divisor_reg = d;
   endfunction

   function int unsigned pending();
      return outcome_q.size();
   endfunction

   // hash the key, search its bucket, append if new and there is room
   function void note_key(input logic [15:0] key);
      int unsigned        d;
      int unsigned        b;
      insert_outcome_type o;
      d = divisor_reg;
      if (d == 0) d = 1;
      if (d > BUCKETS) d = BUCKETS;
      b = key % d;
      o.key = key;
      o.bucket = b[3:0];
      o.status = chs_pkg::INS_OK;
      for (int i = 0; i < bucket_count[b]; i++) begin
         if (stored_keys[b][i] == key) o.status = chs_pkg::INS_DUP;
      end
      if (o.status == chs_pkg::INS_OK) begin
         if (bucket_count[b] >= DEPTH) begin
            o.status = chs_pkg::INS_FULL;
         end else begin
            stored_keys[b][bucket_count[b]] = key;
            bucket_count[b]++;
         end
      end
      case (o.status)
         chs_pkg::INS_OK:  n_inserted++;
         chs_pkg::INS_DUP: n_duplicate++;
         default:          n_full++;
      endcase
      outcome_q.push_back(o);
   endfunction

   // compare one response item with the oldest prediction
   function void check_result(input logic [1:0] status, input logic [3:0] bucket);
      insert_outcome_type o;
      if (outcome_q.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected response status=%0d bucket=%0d", $time, status, bucket);
         return;
      end
      o = outcome_q.pop_front();
      checked++;
      if (status !== o.status || bucket !== o.bucket) begin
         errors++;
         if (errors <= 10)
            $display("%0t: key %h: expected status=%0d bucket=%0d, got status=%0d bucket=%0d",
                     $time, o.key, o.status, o.bucket, status, bucket);
      end
   endfunction
endclass

module chained_hash_set_insert_tb;
   import chs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 70;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [15:0]          req_key_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_insert_status;
   logic [3:0]           rsp_bucket_index;
   logic                 csr_write_en = 1'b0;
   logic [DIV_W-1:0]     csr_hash_divisor = '0;

   logic                 quiet = 1'b0;
   int unsigned          idle_cycles = 0;
   logic [15:0]          sent_keys [$];
   logic [DIV_W-1:0]     phase_div [PHASES] = '{5'd2, 5'd16, 5'd7, 5'd1, 5'd20, 5'd4,
                                                5'd11, 5'd0, 5'd31, 5'd16, 5'd9, 5'd13};

   hash_set_scoreboard   sb = new();

   chained_hash_set_insert #(
      .NUM_BUCKETS(16),
      .BUCKET_DEPTH(8),
      .KEY_WIDTH(16)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_key_value(req_key_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_insert_status(rsp_insert_status),
      .rsp_bucket_index(rsp_bucket_index),
      .csr_write_en(csr_write_en),
      .csr_hash_divisor(csr_hash_divisor)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver stalls at random unless in the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 23);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_insert_status, rsp_bucket_index);
   end

   // watchdog on cycles without any item moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // offer one key, with a random gap first outside the quiet stretch, and wait for acceptance
   task automatic send_key(input logic [15:0] k);
      if (!quiet) begin
         while ($urandom_range(99) < 23) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_key_value <= k;
      do @(posedge clock); while (req_stall);
      sb.note_key(k);
      sent_keys.push_back(k);
   endtask

   // stop sending and wait until every predicted response has arrived
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_divisor(input logic [DIV_W-1:0] d);
      wait_idle();
      csr_hash_divisor <= d;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_divisor(d);
   endtask

   // mostly repeats of earlier keys and fresh random keys, some edge patterns
   function automatic logic [15:0] pick_key();
      int unsigned r;
      int unsigned bitpos;
      r = $urandom_range(99);
      bitpos = $urandom_range(15);
      if (r < 45 && sent_keys.size() > 0)
         return sent_keys[$urandom_range(sent_keys.size() - 1)];
      if (r < 55) begin
         case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001 << bitpos;
            default: return ~(16'h0001 << bitpos);
         endcase
      end
      return 16'($urandom());
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default divisor: fill bucket 0, overflow it, duplicates in a full bucket
      for (int i = 0; i < 9; i++) send_key(16'(i * 13));
      send_key(16'd0);
      send_key(16'd91);
      send_key(16'hFFFF);
      send_key(16'd12);
      send_key(16'hFFFE);
      send_key(16'd12);

      // zero divisor sends everything to the full bucket 0
      write_divisor(5'd0);
      send_key(16'd7);
      send_key(16'd26);

      // oversized divisor saturates; key stored earlier is searched elsewhere
      write_divisor(5'd31);
      send_key(16'd13);
      send_key(16'hFFFF);
      send_key(16'h8000);

      // random phases over a range of divisors, one phase without idling
      for (int p = 0; p < PHASES; p++) begin
         write_divisor(phase_div[p]);
         quiet <= (p == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) send_key(pick_key());
      end
      quiet <= 1'b0;

      wait_idle();
      repeat (30) @(posedge clock);
      sb.errors += sb.pending();
      $display("%0d keys checked over %0d divisor settings plus directed cases",
               sb.checked, PHASES);
      $display("outcomes: %0d inserted, %0d duplicate, %0d bucket full",
               sb.n_inserted, sb.n_duplicate, sb.n_full);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
